@@ design/bfsp_pkg.sv @@
`timescale 1ns / 1ps

package bfsp_pkg;

  // Default sizes of the node and edge stores.
  localparam int BFSP_MAX_NODES = 512;
  localparam int BFSP_MAX_EDGES = 8192;

  // Fixed field widths.
  localparam int NODE_W   = 10;
  localparam int WEIGHT_W = 16;
  localparam int DIST_W   = 32;

  // Operation codes carried by an input transaction.
  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_RUN   = 2'd1,
    OP_QUERY = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  // One stored edge.
  typedef struct packed {
    logic [NODE_W-1:0]          src;
    logic [NODE_W-1:0]          dst;
    logic signed [WEIGHT_W-1:0] weight;
  } edge_t;

  // One entry of a distance array: reached flag and distance.
  typedef struct packed {
    logic                     reached;
    logic signed [DIST_W-1:0] dist_val;
  } dist_word_t;

  // Result of one relaxation step.
  typedef struct packed {
    logic       improve;
    dist_word_t cand;
  } relax_t;

endpackage

@@ design/bellman_ford_shortest_path_core.sv @@
`timescale 1ns / 1ps
// Add edge and clear edges update the edge store when accepted; a query reads the distance
// array, and its result is loaded into an output register once that register is free and held
// there until it is taken. A run clears all MAX_NODES entries of the distance arrays, then per
// round walks the edges through the shared relaxation unit and copies node_count entries.
// Reset is asynchronous and active low; it empties the edge store, sets node_count to 1 and
// leaves every node unreached until the first run.

module bellman_ford_shortest_path_core import bfsp_pkg::*; #(
  parameter int MAX_NODES = BFSP_MAX_NODES,
  parameter int MAX_EDGES = BFSP_MAX_EDGES
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [NODE_W-1:0]          cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 op_i,
  input  logic [NODE_W-1:0]          src_node_i,
  input  logic [NODE_W-1:0]          dst_node_i,
  input  logic signed [WEIGHT_W-1:0] weight_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [DIST_W-1:0]   distance_o,
  output logic                       reachable_o,
  output logic                       negative_cycle_o,
  output logic                       edge_overflow_o
);

  localparam int ETW     = $clog2(MAX_EDGES + 1);
  localparam int EAW     = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int NODE_AW = $clog2(MAX_NODES);
  localparam int RW      = $clog2(MAX_NODES + 1);
  localparam int NCW     = (NODE_W > RW) ? NODE_W : RW;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_CLR   = 8'b0000_0010,
    ST_E_RD  = 8'b0000_0100,
    ST_E_CHK = 8'b0000_1000,
    ST_E_CMP = 8'b0001_0000,
    ST_CP_RD = 8'b0010_0000,
    ST_CP_WR = 8'b0100_0000,
    ST_Q_RD  = 8'b1000_0000
  } state_e;

  // Array index of a node numbered from one.
  function automatic logic [NODE_AW-1:0] node_idx(input logic [NODE_W-1:0] node);
    logic [NCW-1:0] ext;
    ext = NCW'(node) - NCW'(1);
    return ext[NODE_AW-1:0];
  endfunction

  // Node lies in 1..n.
  function automatic logic node_ok(input logic [NODE_W-1:0] node, input logic [RW-1:0] n);
    return (node != '0) && (NCW'(node) <= NCW'(n));
  endfunction

  state_e                   state_q;
  logic [NODE_W-1:0]        node_cnt_q;
  logic [RW-1:0]            run_n_d;
  logic [RW-1:0]            run_n_q;
  logic [RW-1:0]            round_q;
  logic [NODE_AW-1:0]       idx_q;
  logic [ETW-1:0]           edge_idx_q;
  logic                     cycle_q;
  logic                     ran_q;
  logic                     q_ok_q;
  logic                     out_valid_q;
  logic signed [DIST_W-1:0] distance_q;
  logic                     reachable_q;
  logic                     neg_cycle_q;
  logic                     overflow_out_q;

  logic                     in_fire;
  op_e                      op;
  logic                     last_round;
  logic                     edge_ok;
  logic                     out_free;
  edge_t                    wr_edge;
  edge_t                    edge_rd;
  logic [ETW-1:0]           edge_total;
  logic                     overflow;
  relax_t                   relax;

  logic                     cur_we;
  logic [NODE_AW-1:0]       cur_waddr;
  dist_word_t               cur_wdata;
  logic                     cur_re;
  logic [NODE_AW-1:0]       cur_raddr;
  dist_word_t               cur_rd;
  logic                     nxt_we;
  logic [NODE_AW-1:0]       nxt_waddr;
  dist_word_t               nxt_wdata;
  logic                     nxt_re;
  logic [NODE_AW-1:0]       nxt_raddr;
  dist_word_t               nxt_rd;

  assign op         = op_e'(op_i);
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign last_round = ((round_q + RW'(1)) == run_n_q);
  assign edge_ok    = node_ok(edge_rd.src, run_n_q) && node_ok(edge_rd.dst, run_n_q);
  assign out_free   = !out_valid_q || out_ready_i;

  // Node count clamped to 1..MAX_NODES.
  always_comb begin
    if (node_cnt_q == '0) begin
      run_n_d = RW'(1);
    end else if (NCW'(node_cnt_q) > NCW'(MAX_NODES)) begin
      run_n_d = RW'(MAX_NODES);
    end else begin
      run_n_d = RW'(node_cnt_q);
    end
  end

  // Edge store.
  assign wr_edge.src    = src_node_i;
  assign wr_edge.dst    = dst_node_i;
  assign wr_edge.weight = weight_i;

  bfsp_edge_store #(
    .MAX_EDGES (MAX_EDGES)
  ) u_edge_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .add_i      (in_fire && (op == OP_ADD)),
    .clr_i      (in_fire && (op == OP_CLEAR)),
    .wr_edge_i  (wr_edge),
    .rd_en_i    ((state_q == ST_E_RD) && (edge_idx_q != edge_total)),
    .rd_addr_i  (edge_idx_q[EAW-1:0]),
    .rd_edge_o  (edge_rd),
    .total_o    (edge_total),
    .overflow_o (overflow)
  );

  // Current-round and next-round distance arrays.
  bfsp_dist_ram #(
    .DEPTH (MAX_NODES)
  ) u_cur_ram (
    .clk_i   (clk_i),
    .we_i    (cur_we),
    .waddr_i (cur_waddr),
    .wdata_i (cur_wdata),
    .re_i    (cur_re),
    .raddr_i (cur_raddr),
    .rdata_o (cur_rd)
  );

  bfsp_dist_ram #(
    .DEPTH (MAX_NODES)
  ) u_nxt_ram (
    .clk_i   (clk_i),
    .we_i    (nxt_we),
    .waddr_i (nxt_waddr),
    .wdata_i (nxt_wdata),
    .re_i    (nxt_re),
    .raddr_i (nxt_raddr),
    .rdata_o (nxt_rd)
  );

  // Shared relaxation unit.
  bfsp_relax_alu u_relax_alu (
    .src_i    (cur_rd),
    .dst_i    (nxt_rd),
    .weight_i (edge_rd.weight),
    .res_o    (relax)
  );

  // Memory port steering by sequencer state.
  always_comb begin
    cur_we    = 1'b0;
    cur_waddr = idx_q;
    cur_wdata = nxt_rd;
    cur_re    = 1'b0;
    cur_raddr = node_idx(edge_rd.src);
    nxt_we    = 1'b0;
    nxt_waddr = node_idx(edge_rd.dst);
    nxt_wdata = relax.cand;
    nxt_re    = 1'b0;
    nxt_raddr = node_idx(edge_rd.dst);
    unique case (state_q)
      ST_IDLE: begin
        cur_re    = in_fire && (op == OP_QUERY);
        cur_raddr = node_idx(src_node_i);
      end
      ST_CLR: begin
        cur_we             = 1'b1;
        cur_wdata.reached  = (idx_q == '0);
        cur_wdata.dist_val = '0;
        nxt_we             = 1'b1;
        nxt_waddr          = idx_q;
        nxt_wdata          = cur_wdata;
      end
      ST_E_CHK: begin
        cur_re = edge_ok;
        nxt_re = edge_ok;
      end
      ST_E_CMP: begin
        nxt_we = relax.improve && !last_round;
      end
      ST_CP_RD: begin
        nxt_re    = 1'b1;
        nxt_raddr = idx_q;
      end
      ST_CP_WR: begin
        cur_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_cnt_q <= NODE_W'(1);
    end else if (cfg_we_i) begin
      node_cnt_q <= cfg_wdata_i;
    end
  end

  // Sequencer: clear pass, edge walk per round, copy pass per round, and query read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      run_n_q     <= RW'(1);
      round_q     <= '0;
      idx_q       <= '0;
      edge_idx_q  <= '0;
      cycle_q     <= 1'b0;
      ran_q       <= 1'b0;
      q_ok_q      <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire && (op == OP_RUN)) begin
            run_n_q <= run_n_d;
            cycle_q <= 1'b0;
            idx_q   <= '0;
            state_q <= ST_CLR;
          end else if (in_fire && (op == OP_QUERY)) begin
            q_ok_q  <= ran_q && node_ok(src_node_i, run_n_d);
            state_q <= ST_Q_RD;
          end
        end
        ST_CLR: begin
          if (idx_q == NODE_AW'(MAX_NODES - 1)) begin
            round_q    <= '0;
            edge_idx_q <= '0;
            state_q    <= ST_E_RD;
          end else begin
            idx_q <= idx_q + NODE_AW'(1);
          end
        end
        ST_E_RD: begin
          if (edge_idx_q == edge_total) begin
            idx_q   <= '0;
            state_q <= ST_CP_RD;
          end else begin
            state_q <= ST_E_CHK;
          end
        end
        ST_E_CHK: begin
          if (edge_ok) begin
            state_q <= ST_E_CMP;
          end else begin
            edge_idx_q <= edge_idx_q + ETW'(1);
            state_q    <= ST_E_RD;
          end
        end
        ST_E_CMP: begin
          // In the final round an improvement is only recorded.
          if (relax.improve && last_round) begin
            cycle_q <= 1'b1;
          end
          edge_idx_q <= edge_idx_q + ETW'(1);
          state_q    <= ST_E_RD;
        end
        ST_CP_RD: begin
          state_q <= ST_CP_WR;
        end
        ST_CP_WR: begin
          if (RW'(idx_q) == (run_n_q - RW'(1))) begin
            round_q <= round_q + RW'(1);
            if (last_round) begin
              ran_q   <= 1'b1;
              state_q <= ST_IDLE;
            end else begin
              edge_idx_q <= '0;
              state_q    <= ST_E_RD;
            end
          end else begin
            idx_q   <= idx_q + NODE_AW'(1);
            state_q <= ST_CP_RD;
          end
        end
        ST_Q_RD: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Output handshake: a result transaction is held until the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_Q_RD) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_Q_RD) && out_free) begin
      reachable_q    <= q_ok_q && cur_rd.reached;
      distance_q     <= (q_ok_q && cur_rd.reached) ? cur_rd.dist_val : '0;
      neg_cycle_q    <= cycle_q;
      overflow_out_q <= overflow;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign distance_o       = distance_q;
  assign reachable_o      = reachable_q;
  assign negative_cycle_o = neg_cycle_q;
  assign edge_overflow_o  = overflow_out_q;

  // A relaxation only runs on an edge inside the stored list.
  a_cmp_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_E_CMP) |-> (edge_idx_q < edge_total))
    else $error("relaxation beyond the stored edge list");

  // The cycle flag is set only by a comparison in the final round.
  a_cycle_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(cycle_q) |-> (($past(state_q) == ST_E_CMP)
                        && (($past(round_q) + RW'(1)) == $past(run_n_q))))
    else $error("negative cycle flagged outside the final round");

  // A run ends after exactly node_count rounds.
  a_run_rounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (($past(state_q) == ST_CP_WR) && (state_q == ST_IDLE)) |-> (round_q == run_n_q))
    else $error("run ended with the wrong number of rounds");

endmodule

@@ design/bfsp_edge_store.sv @@
`timescale 1ns / 1ps

module bfsp_edge_store import bfsp_pkg::*; #(
  parameter int MAX_EDGES = BFSP_MAX_EDGES,
  localparam int ETW = $clog2(MAX_EDGES + 1),
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           add_i,
  input  logic           clr_i,
  input  edge_t          wr_edge_i,
  input  logic           rd_en_i,
  input  logic [EAW-1:0] rd_addr_i,
  output edge_t          rd_edge_o,
  output logic [ETW-1:0] total_o,
  output logic           overflow_o
);

  edge_t          mem_q [MAX_EDGES];
  edge_t          rd_edge_q;
  logic [ETW-1:0] total_q;
  logic           overflow_q;
  logic           full;

  assign full = (total_q == ETW'(MAX_EDGES));

  // Fill count and overflow flag; a clear empties the store.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q    <= '0;
      overflow_q <= 1'b0;
    end else if (clr_i) begin
      total_q    <= '0;
      overflow_q <= 1'b0;
    end else if (add_i) begin
      if (full) begin
        overflow_q <= 1'b1;
      end else begin
        total_q <= total_q + ETW'(1);
      end
    end
  end

  // Edge memory with one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (add_i && !full) begin
      mem_q[total_q[EAW-1:0]] <= wr_edge_i;
    end
    if (rd_en_i) begin
      rd_edge_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_edge_o  = rd_edge_q;
  assign total_o    = total_q;
  assign overflow_o = overflow_q;

  // The fill count never passes the store depth.
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= ETW'(MAX_EDGES))
    else $error("edge count exceeds store depth");

  // An edge is only dropped once the store is full.
  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    overflow_q |-> full)
    else $error("overflow flagged with room left in the store");

endmodule

@@ design/bfsp_dist_ram.sv @@
`timescale 1ns / 1ps

module bfsp_dist_ram import bfsp_pkg::*; #(
  parameter int DEPTH = BFSP_MAX_NODES,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  dist_word_t    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output dist_word_t    rdata_o
);

  dist_word_t mem_q [DEPTH];
  dist_word_t rdata_q;

  // One write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/bfsp_relax_alu.sv @@
`timescale 1ns / 1ps

module bfsp_relax_alu import bfsp_pkg::*; (
  input  dist_word_t                 src_i,
  input  dist_word_t                 dst_i,
  input  logic signed [WEIGHT_W-1:0] weight_i,
  output relax_t                     res_o
);

  logic signed [DIST_W:0] cand;
  logic signed [DIST_W:0] dst_ext;

  // Candidate distance through this edge, one bit wider than a stored distance.
  assign cand = $signed({src_i.dist_val[DIST_W-1], src_i.dist_val})
              + $signed({{(DIST_W + 1 - WEIGHT_W){weight_i[WEIGHT_W-1]}}, weight_i});
  assign dst_ext = $signed({dst_i.dist_val[DIST_W-1], dst_i.dist_val});

  // The target improves when the source is reached and the target is unreached or holds a larger distance.
  assign res_o.improve       = src_i.reached && (!dst_i.reached || (dst_ext > cand));
  assign res_o.cand.reached  = 1'b1;
  assign res_o.cand.dist_val = cand[DIST_W-1:0];

endmodule
